// File: design/lomu_pkg.sv
// lomu_pkg: shared types, sizes and helpers for the limit order matching unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lomu_pkg;

  localparam int BOOK_DEPTH = 32;
  localparam int PRICE_BITS = 16;

  localparam int IDX_W   = $clog2(BOOK_DEPTH);
  localparam int CNT_W   = $clog2(BOOK_DEPTH + 1);
  localparam int ID_W    = 32;
  localparam int SIZE_W  = 32;
  localparam int PRICE_W = 16;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef logic [PRICE_BITS-1:0] bprice_t;

  typedef struct packed {
    logic [ID_W-1:0]    order_num;
    logic               order_side;
    logic [PRICE_W-1:0] order_price;
    logic [SIZE_W-1:0]  order_qty;
  } order_t;

  typedef struct packed {
    logic               is_trade;
    logic [ID_W-1:0]    maker_num;
    logic [PRICE_W-1:0] maker_price;
    logic [SIZE_W-1:0]  fill_size;
    logic [ID_W-1:0]    taker_num;
    logic [SIZE_W-1:0]  left_size;
    logic               booked;
    logic               dropped_full;
    logic [31:0]        trades_so_far;
    logic               last_item;
  } result_t;

  typedef struct packed {
    logic              side;
    bprice_t           price;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   ident;
  } slot_t;

  typedef struct packed {
    logic              remove;
    logic              update;
    logic              append;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
    slot_t             slot;
  } book_cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    slot_t            slot;
  } best_t;

  function automatic bprice_t to_book_price(input logic [PRICE_W-1:0] p);
    logic [31:0] w;
    w = {16'b0, p};
    return w[PRICE_BITS-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] from_book_price(input bprice_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[PRICE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/lomu_book.sv
// lomu_book: resting order table kept compact in arrival order, oldest at slot 0
// depends on lomu_pkg; one read port at the scan pointer, one command a cycle
`timescale 1ns / 1ps
`default_nettype none

module lomu_book (
  input  wire                          clk,
  input  wire                          rst_n,
  input  lomu_pkg::book_cmd_t          cmd,
  input  wire [lomu_pkg::IDX_W-1:0]    rd_idx,
  output lomu_pkg::slot_t              rd_slot,
  output logic [lomu_pkg::CNT_W-1:0]   count,
  output logic                         full
);
  import lomu_pkg::*;

  slot_t            slot_r   [BOOK_DEPTH];
  slot_t            slot_nxt [BOOK_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (cmd.remove) begin
      for (int i = 0; i < BOOK_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= cmd.idx) begin
          slot_nxt[i] = slot_r[i+1];
        end
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (cmd.update) begin
      slot_nxt[cmd.idx].size = cmd.size;
    end else if (cmd.append) begin
      slot_nxt[cnt_r[IDX_W-1:0]] = cmd.slot;
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_slot = slot_r[rd_idx];
  assign count   = cnt_r;
  assign full    = (cnt_r == CNT_W'(BOOK_DEPTH));

endmodule

`default_nettype wire

// File: design/lomu_best.sv
// lomu_best: price compare unit, one slot per cycle while en is high, keeps the best crossing slot
// depends on lomu_pkg; strict compare keeps the oldest slot among equal prices
`timescale 1ns / 1ps
`default_nettype none

module lomu_best (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       clear,
  input  wire                       en,
  input  wire                       side,
  input  lomu_pkg::bprice_t         limit,
  input  lomu_pkg::slot_t           cand,
  input  wire [lomu_pkg::IDX_W-1:0] cand_idx,
  output lomu_pkg::best_t           best
);
  import lomu_pkg::*;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  slot_t            slot_r, slot_nxt;
  logic             crosses, better;

  always_comb begin
    if (side == SIDE_BUY) begin
      crosses = (cand.side != side) && (cand.price <= limit);
      better  = !found_r || (cand.price < slot_r.price);
    end else begin
      crosses = (cand.side != side) && (cand.price >= limit);
      better  = !found_r || (cand.price > slot_r.price);
    end
  end

  always_comb begin
    found_nxt = found_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    if (clear) begin
      found_nxt = 1'b0;
    end else if (en && crosses && better) begin
      found_nxt = 1'b1;
      idx_nxt   = cand_idx;
      slot_nxt  = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
  end

  assign best.found = found_r;
  assign best.idx   = idx_r;
  assign best.slot  = slot_r;

endmodule

`default_nettype wire

// File: design/limit_order_matching_unit.sv
// limit_order_matching_unit: price-time priority matching of limit orders against a book
// depends on lomu_pkg, lomu_book, lomu_best
//
//   channel   ports                      handshake
//   input     start, busy, in_order      taken when start && !busy
//   result    out_valid, out_result      one-cycle strobe, cannot be held off
//
// each scan pass walks the resting slots through one compare unit, then a decide
// step takes at most one fill from the best crossing slot; passes repeat until no
// slot crosses, the size runs out or the item reaches the fill limit (BOOK_DEPTH fills)
// busy is high from acceptance until the summary item is on the outputs
// reset empties the book and clears the trade count; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module limit_order_matching_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  lomu_pkg::order_t  in_order,
  output logic              out_valid,
  output lomu_pkg::result_t out_result
);
  import lomu_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_PLACE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  ntr_r, ntr_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              side_r, side_nxt;
  bprice_t           price_r, price_nxt;
  logic [SIZE_W-1:0] left_r, left_nxt;
  logic [31:0]       total_r, total_nxt, total_inc;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;

  book_cmd_t         cmd;
  slot_t             rd_slot;
  logic [CNT_W-1:0]  count;
  logic              full;
  best_t             best;
  logic              best_clear, best_en;

  logic              left_small;
  logic [SIZE_W-1:0] fill, left_after, size_after;

  lomu_book u_book (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_idx  (ptr_r[IDX_W-1:0]),
    .rd_slot (rd_slot),
    .count   (count),
    .full    (full)
  );

  lomu_best u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (best_clear),
    .en       (best_en),
    .side     (side_r),
    .limit    (price_r),
    .cand     (rd_slot),
    .cand_idx (ptr_r[IDX_W-1:0]),
    .best     (best)
  );

  assign left_small = left_r < best.slot.size;
  assign fill       = left_small ? left_r : best.slot.size;
  assign left_after = left_small ? '0 : left_r - best.slot.size;
  assign size_after = left_small ? best.slot.size - left_r : '0;
  assign total_inc  = (total_r == 32'hFFFF_FFFF) ? total_r : total_r + 32'd1;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    ntr_nxt       = ntr_r;
    id_nxt        = id_r;
    side_nxt      = side_r;
    price_nxt     = price_r;
    left_nxt      = left_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    best_clear    = 1'b0;
    best_en       = 1'b0;
    cmd           = '0;
    cmd.idx       = best.idx;
    cmd.size      = size_after;
    cmd.slot      = '{side: side_r, price: price_r, size: left_r, ident: id_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          id_nxt     = in_order.order_num;
          side_nxt   = in_order.order_side;
          price_nxt  = to_book_price(in_order.order_price);
          left_nxt   = in_order.order_qty;
          ntr_nxt    = '0;
          ptr_nxt    = '0;
          best_clear = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (left_r == '0 || ntr_r == CNT_W'(BOOK_DEPTH)) begin
          state_nxt = S_PLACE;
        end else if (ptr_r == count) begin
          state_nxt = S_DECIDE;
        end else begin
          best_en = 1'b1;
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        if (best.found) begin
          left_nxt       = left_after;
          total_nxt      = total_inc;
          ntr_nxt        = ntr_r + CNT_W'(1);
          cmd.remove     = (size_after == '0);
          cmd.update     = (size_after != '0);
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.is_trade      = 1'b1;
          out_nxt.maker_num     = best.slot.ident;
          out_nxt.maker_price   = from_book_price(best.slot.price);
          out_nxt.fill_size     = fill;
          out_nxt.taker_num     = id_r;
          out_nxt.left_size     = left_after;
          out_nxt.trades_so_far = total_inc;
          ptr_nxt    = '0;
          best_clear = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.append            = (left_r != '0) && !full;
        out_valid_nxt         = 1'b1;
        out_nxt               = '0;
        out_nxt.taker_num     = id_r;
        out_nxt.left_size     = left_r;
        out_nxt.booked        = (left_r != '0) && !full;
        out_nxt.dropped_full  = (left_r != '0) && full;
        out_nxt.trades_so_far = total_r;
        out_nxt.last_item     = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    ntr_r   <= ntr_nxt;
    id_r    <= id_nxt;
    side_r  <= side_nxt;
    price_r <= price_nxt;
    left_r  <= left_nxt;
    out_r   <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // summary goes out as the block returns to idle
  a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.last_item |-> !busy)
    else $error("summary item while still busy");

  a_book_or_drop : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result.booked && out_result.dropped_full))
    else $error("remainder both booked and dropped");

  a_fill_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.is_trade |-> out_result.fill_size != '0)
    else $error("trade item with zero fill");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted item did not raise busy");

endmodule

`default_nettype wire
